### rtl/rxf_pkg.sv
// ============================================================================
// rxf_pkg
// Shared constants and types for the receive FIFO with RTS watermark control.
// ============================================================================
package rxf_pkg;

    // Ring buffer geometry
    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int FREE_W  = PTR_W + 1;
    localparam int DATA_W  = 8;

    // Configuration port
    localparam int THR_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = THR_W;
    localparam int CMP_W   = (FREE_W > THR_W) ? FREE_W : THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RTS_AUTO_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD  = CFG_IDX_W'(1);

    localparam logic             RTS_AUTO_RESET = 1'b1;
    localparam logic [THR_W-1:0] THR_RESET      = THR_W'(8);

    // Opcodes
    localparam logic OP_RX  = 1'b0;
    localparam logic OP_POP = 1'b1;

    // Buffer memory access
    typedef struct packed {
        logic             we;
        logic             re;
        logic [PTR_W-1:0] addr;
    } t_ram_req;

    // Per-item result, minus the data which comes from the memory
    typedef struct packed {
        logic pop_valid;
        logic rts_level;
    } t_res;

endpackage

### rtl/rxf_ram.sv
// ============================================================================
// rxf_ram
// Generic single-port synchronous RAM, registered read.
// ============================================================================
module rxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rxf_ctrl.sv
// ============================================================================
// rxf_ctrl
// Pointer, RTS and configuration state; issues at most one buffer access per item.
// ============================================================================
module rxf_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_opcode,
    input  logic                             i_rx_error,
    input  logic                             i_cfg_wr,
    input  logic [rxf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rxf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rxf_pkg::t_ram_req                o_ram_req,
    output rxf_pkg::t_res                    o_res
);
    import rxf_pkg::*;

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic             r_rts, n_rts;
    logic             r_auto_en;
    logic [THR_W-1:0] r_thr;

    logic             empty;
    logic [FREE_W-1:0] free_sp;
    logic [CMP_W-1:0]  free_cmp;
    logic [CMP_W-1:0]  thr_cmp;
    logic [CMP_W-1:0]  half_cmp;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        f_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Free entries after this item's pointer update
    always_comb begin
        if (n_wp >= n_rp) begin
            free_sp = {1'b0, n_rp} + FREE_W'(DEPTH) - {1'b0, n_wp};
        end else begin
            free_sp = {1'b0, n_rp} - {1'b0, n_wp};
        end
    end

    assign empty    = (r_wp == r_rp);
    assign free_cmp = CMP_W'(free_sp);
    assign thr_cmp  = CMP_W'(r_thr);
    assign half_cmp = CMP_W'(DEPTH / 2);

    always_comb begin
        n_wp          = r_wp;
        n_rp          = r_rp;
        o_ram_req.we  = 1'b0;
        o_ram_req.re  = 1'b0;
        o_ram_req.addr = r_wp;
        o_res.pop_valid = 1'b0;
        if (i_accept) begin
            if (i_opcode == OP_RX) begin
                if (!i_rx_error) begin
                    o_ram_req.we = 1'b1;
                    n_wp         = f_next(r_wp);
                end
            end else begin
                o_ram_req.addr = r_rp;
                if (!empty) begin
                    o_ram_req.re    = 1'b1;
                    o_res.pop_valid = 1'b1;
                    n_rp            = f_next(r_rp);
                end
            end
        end
    end

    always_comb begin
        n_rts = r_rts;
        if (i_accept && r_auto_en) begin
            if (i_opcode == OP_RX) begin
                if (!i_rx_error && (free_cmp <= thr_cmp)) begin
                    n_rts = 1'b1;
                end
            end else if (empty || (free_cmp >= half_cmp)) begin
                n_rts = 1'b0;
            end
        end
    end

    assign o_res.rts_level = n_rts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_rts     <= 1'b0;
            r_auto_en <= RTS_AUTO_RESET;
            r_thr     <= THR_RESET;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_rts <= n_rts;
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_RTS_AUTO_ENABLE: r_auto_en <= i_cfg_data[0];
                    CFG_FREE_THRESHOLD:  r_thr     <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/rx_fifo_rts_flow_control.sv
// ============================================================================
// rx_fifo_rts_flow_control
// UART receive ring buffer with automatic RTS watermark flow control.
// ============================================================================
// Each item is either a received byte (opcode 0) or a pop (opcode 1) and
// yields exactly one result item carrying pop_valid, pop_data and the RTS
// level after the item. A byte flagged with rx_error is dropped. There is no
// full check: writing past a full buffer overwrites, and once the write
// pointer meets the read pointer the buffer reads as empty. With automatic
// RTS on, a stored byte raises RTS when free space is at or below the
// threshold; a pop lowers it on an empty buffer or once free space reaches
// half the depth. The bytes live in a single-port RAM; every item makes at
// most one access to it, so one item is taken every clock cycle while the
// output side is not stalled; a result passes through the registered RAM
// read (stage 1) and then the output register. The buffer needs no clearing
// pass after reset. Configuration writes are always ready and must only be
// made while the block is idle.
// ============================================================================
module rx_fifo_rts_flow_control (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [rxf_pkg::DATA_W-1:0]     i_rx_byte,
    input  logic                           i_rx_error,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_pop_valid,
    output logic [rxf_pkg::DATA_W-1:0]     o_pop_data,
    output logic                           o_rts_level,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rxf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rxf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rxf_pkg::*;

    t_ram_req          ram_req;
    t_res              res;
    logic [DATA_W-1:0] ram_rdata;

    logic accept;
    logic s1_move;

    // stage 1: waits for the RAM read data
    logic r_s1_vld;
    t_res r_s1_res;

    // output register
    logic              r_out_vld;
    logic              r_out_pop_vld;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_rts;

    // Stage 1 advances when the output register is empty or being taken.
    // The RAM read register is only loaded on accept, so it holds while
    // stage 1 is stalled.
    assign s1_move    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    rxf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_rx_error  (i_rx_error),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ram_req   (ram_req),
        .o_res       (res)
    );

    rxf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_re    (ram_req.re),
        .i_addr  (ram_req.addr),
        .i_wdata (i_rx_byte),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= res;
        end
        if (s1_move && r_s1_vld) begin
            r_out_pop_vld <= r_s1_res.pop_valid;
            r_out_data    <= r_s1_res.pop_valid ? ram_rdata : '0;
            r_out_rts     <= r_s1_res.rts_level;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pop_valid = r_out_pop_vld;
    assign o_pop_data  = r_out_data;
    assign o_rts_level = r_out_rts;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the receive FIFO with RTS watermark control.
// ============================================================================
// Items go in through the valid/stall input channel. Each accepted item is
// run through a behavioural copy of the ring buffer kept in this bench, and
// the predicted result is queued. Every result the block hands over is
// checked field by field against the oldest queued prediction.
//
// Configuration is only written once the result queue has drained.
// Directed tests come first, then a stretch with no idling, then random
// fill/drain traffic over a range of threshold and auto-RTS settings.
// Both sides idle at random everywhere except in the no-idling stretch.
// ============================================================================
module tb_top;
    import rxf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;

    // Indexes past the last register; writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} t_burst_kind;

    typedef struct packed {
        logic              pop_valid;
        logic [DATA_W-1:0] pop_data;
        logic              rts_level;
    } t_rx_result;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_opcode    = OP_RX;
    logic [DATA_W-1:0]     i_rx_byte   = '0;
    logic                  i_rx_error  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_pop_valid;
    logic [DATA_W-1:0]     o_pop_data;
    logic                  o_rts_level;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    rx_fifo_rts_flow_control uut (.*);

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the ring buffer, its pointers, RTS and the two registers
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] fifo_bytes [DEPTH];
    int unsigned       wr_idx    = 0;
    int unsigned       rd_idx    = 0;
    logic              rts_now   = 1'b0;
    logic              auto_rts  = RTS_AUTO_RESET;
    logic [THR_W-1:0]  threshold = THR_RESET;

    t_rx_result pending_results [$];

    bit calm = 1'b0;        // set: neither side idles
    int fail_count   = 0;
    int results_seen = 0;
    int total_items  = 0;
    int useful_items = 0;   // error bytes are dropped by the block, not counted
    int data_pops    = 0;
    int rts_rises    = 0;
    int cfg_writes   = 0;

    // Equal pointers read as empty, i.e. the whole depth free
    function automatic int unsigned free_slots();
        return (wr_idx >= rd_idx) ? rd_idx + DEPTH - wr_idx : rd_idx - wr_idx;
    endfunction

    // Applies one item to the shadow state and returns the result it causes
    function automatic t_rx_result predict_rx_fifo(logic op, logic [DATA_W-1:0] data,
                                                   logic err);
        t_rx_result res;
        res = '0;
        if (op == OP_RX) begin
            // a byte with a line error leaves everything untouched
            if (!err) begin
                fifo_bytes[wr_idx] = data;
                wr_idx = (wr_idx + 1) % DEPTH;
                if (auto_rts && free_slots() <= threshold) begin
                    if (!rts_now)
                        rts_rises++;
                    rts_now = 1'b1;
                end
            end
        end else if (wr_idx == rd_idx) begin
            // pop on empty: nothing returned, RTS dropped if automatic
            if (auto_rts)
                rts_now = 1'b0;
        end else begin
            res.pop_valid = 1'b1;
            res.pop_data  = fifo_bytes[rd_idx];
            rd_idx = (rd_idx + 1) % DEPTH;
            if (auto_rts && free_slots() >= DEPTH / 2)
                rts_now = 1'b0;
            data_pops++;
        end
        res.rts_level = rts_now;
        return res;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side: one item per call, with a random idle gap in front
    // ------------------------------------------------------------------------
    task automatic send_item(logic op, logic [DATA_W-1:0] data, logic err);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 10)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= data;
        i_rx_error <= err;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        // accepted at this edge
        pending_results.push_back(predict_rx_fifo(op, data, err));
        total_items++;
        if (!(op == OP_RX && err))
            useful_items++;
    endtask

    // Stops sending and waits until every predicted result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write, only ever made with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_RTS_AUTO_ENABLE: auto_rts  = data[0];
            CFG_FREE_THRESHOLD:  threshold = data;
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A run of mostly stores, mostly pops, or an even mix, with random bytes
    task automatic run_burst(t_burst_kind kind);
        int   n;
        logic op;
        case (kind)
            BURST_FILL:  n = $urandom_range(1, DEPTH + 8);
            BURST_DRAIN: n = $urandom_range(1, DEPTH + 4);
            default:     n = $urandom_range(8, 48);
        endcase
        repeat (n) begin
            case (kind)
                BURST_FILL:  op = ($urandom_range(19) == 0) ? OP_POP : OP_RX;
                BURST_DRAIN: op = ($urandom_range(19) == 0) ? OP_RX : OP_POP;
                default:     op = $urandom_range(1) ? OP_POP : OP_RX;
            endcase
            send_item(op, DATA_W'($urandom), $urandom_range(9) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stall, and the result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < 10);

    always @(posedge i_clk) begin : check_results
        t_rx_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("nothing expected, got valid=%0b data=%02h rts=%0b",
                                       o_pop_valid, o_pop_data, o_rts_level));
            end else begin
                want = pending_results.pop_front();
                if (o_pop_valid !== want.pop_valid)
                    note_failure($sformatf("pop_valid exp %0b got %0b",
                                           want.pop_valid, o_pop_valid));
                if (o_pop_data !== want.pop_data)
                    note_failure($sformatf("pop_data exp %02h got %02h",
                                           want.pop_data, o_pop_data));
                if (o_rts_level !== want.rts_level)
                    note_failure($sformatf("rts_level exp %0b got %0b",
                                           want.rts_level, o_rts_level));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: empty pops, data extremes, a dropped error byte
    task automatic test_reset_defaults();
        send_item(OP_POP, 8'h00, 1'b0);     // empty straight out of reset
        send_item(OP_RX,  8'h00, 1'b0);
        send_item(OP_RX,  8'hFF, 1'b0);
        send_item(OP_RX,  8'hA5, 1'b1);     // line error, dropped
        send_item(OP_POP, 8'hFF, 1'b1);     // byte and error are don't-care on a pop
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);     // empty again
    endtask

    // Threshold extremes, RTS held with auto off, spare register indexes
    task automatic test_threshold_extremes();
        write_reg(CFG_FREE_THRESHOLD, '1);              // beyond any free count
        send_item(OP_RX, 8'h5A, 1'b0);                  // raises RTS at once
        write_reg(CFG_RTS_AUTO_ENABLE, CFG_DATA_W'(7'h7E));  // off, upper bits junk
        send_item(OP_POP, 8'h00, 1'b0);                 // RTS must hold
        send_item(OP_POP, 8'h00, 1'b0);                 // empty, RTS still held
        write_reg(CFG_RTS_AUTO_ENABLE, CFG_DATA_W'(7'h01));
        send_item(OP_POP, 8'h00, 1'b0);                 // empty pop drops RTS
        write_reg(CFG_FREE_THRESHOLD, '0);              // never reached
        send_item(OP_RX, 8'h3C, 1'b0);
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '0);
        send_item(OP_RX, 8'hC3, 1'b0);
        write_reg(CFG_FREE_THRESHOLD, CFG_DATA_W'(DEPTH));
        send_item(OP_RX, 8'h81, 1'b0);                  // raises
        send_item(OP_POP, 8'h00, 1'b0);                 // half free, drops
        send_item(OP_POP, 8'h00, 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);
    endtask

    // No full check: a full lap reads as empty, a lap and a bit leaves the bit
    task automatic test_overwrite_wrap();
        write_reg(CFG_FREE_THRESHOLD, THR_RESET);
        write_reg(CFG_RTS_AUTO_ENABLE, CFG_DATA_W'(1));
        repeat (DEPTH) send_item(OP_RX, DATA_W'($urandom), 1'b0);
        send_item(OP_POP, 8'h00, 1'b0);
        repeat (DEPTH + 6) send_item(OP_RX, DATA_W'($urandom), 1'b0);
        repeat (7) send_item(OP_POP, 8'h00, 1'b0);
    endtask

    // Long stretch at full rate on both sides
    task automatic test_back_to_back();
        calm = 1'b1;
        repeat (10) run_burst(t_burst_kind'($urandom_range(2)));
        wait_idle();
        calm = 1'b0;
    endtask

    // Random settings per phase, fill/drain bursts within each phase
    task automatic test_random_traffic();
        int                    target;
        logic [CFG_DATA_W-1:0] cfg_word;
        target = useful_items + RANDOM_ITEMS;
        while (useful_items < target) begin
            case ($urandom_range(7))
                0:       cfg_word = '0;
                1:       cfg_word = '1;
                2:       cfg_word = CFG_DATA_W'(DEPTH);
                3:       cfg_word = CFG_DATA_W'(DEPTH / 2);
                4:       cfg_word = THR_RESET;
                default: cfg_word = CFG_DATA_W'($urandom_range(DEPTH));
            endcase
            write_reg(CFG_FREE_THRESHOLD, cfg_word);
            // auto-RTS on most of the time; upper data bits random
            cfg_word    = CFG_DATA_W'($urandom);
            cfg_word[0] = ($urandom_range(7) != 0);
            write_reg(CFG_RTS_AUTO_ENABLE, cfg_word);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
                          CFG_DATA_W'($urandom));
            repeat (4) run_burst(t_burst_kind'($urandom_range(2)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequencing and end of run
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_threshold_extremes();
        test_overwrite_wrap();
        test_back_to_back();
        test_random_traffic();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items: %0d pops returned data, RTS went up %0d times",
                 total_items, data_pops, rts_rises);
        $display("%0d register writes across threshold/auto-RTS settings, %0d mismatches",
                 cfg_writes, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still due",
                 cycle_count, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/rxf_pkg.sv
rtl/rxf_ram.sv
rtl/rxf_ctrl.sv
rtl/rx_fifo_rts_flow_control.sv
dv/tb_top.sv
